@@ hw/rtl/srf_pkg.sv @@
// srf_pkg: shared types and constants of the singleton relation filter
// used by srf_ctrl, srf_datapath and singleton_relation_filter
`timescale 1ns / 1ps

package srf_pkg;

	// weight table geometry
	localparam int TABLE_DEPTH = 1048576;
	localparam int TBL_AW      = $clog2(TABLE_DEPTH);
	localparam int NZ_W        = $clog2(TABLE_DEPTH + 1);

	// field widths
	localparam int IDX_W    = 20;
	localparam int WEIGHT_W = 8;
	localparam int LIMIT_W  = 21;
	localparam int CNT_W    = 32;
	localparam int NZOUT_W  = 21;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 88;

	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 8'd255;

	// configuration register indices
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_LIMIT = 1'b1;

	localparam logic [LIMIT_W-1:0] COL_LIMIT_RST = 21'd1048576;

	// controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_wr;
		logic accept;
		logic update;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic emit_stall;
	} dp_status_t;

endpackage

@@ hw/rtl/singleton_relation_filter.sv @@
// singleton_relation_filter: top level of the singleton relation filter
// depends on srf_pkg, srf_ctrl and srf_datapath
`timescale 1ns / 1ps

// Each ideal index is a read-modify-write of the weight table: a registered
// read when the word is accepted, then the update and write-back, before the
// next word is taken. A finished relation's result sits in an output
// register, so the next word is accepted while it waits; a relation end is
// held only while that register is still occupied. After reset the weight
// table is swept to zero, one entry per cycle; no word is accepted during
// that pass, though configuration writes are taken. Configuration is to be
// written only while the block is idle; a write of pass_mode clears the
// relation counters and any partial relation.

module singleton_relation_filter
	import srf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [LIMIT_W-1:0]     cfg_data,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [19:0] ideal_index, rest zero
	input  logic                   s_tlast,  // last_in_relation
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] keep_relation, [1] index_out_of_range, [2] zero_weight_seen,
	// [23:3] nonzero_ideals, [55:24] relations_seen, [87:56] relations_kept
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// controller
	srf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	srf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_idx    (s_tdata[IDX_W-1:0]),
		.in_last   (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

@@ hw/rtl/srf_ctrl.sv @@
// srf_ctrl: sequencing of the table clearing pass and the per-word
// read-modify-write; depends on srf_pkg
`timescale 1ns / 1ps

module srf_ctrl
	import srf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				// a finishing word waits for the output slot
				if (!status.emit_stall) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// no word is taken before the table is clear
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("word accepted during clearing pass");

	// an accepted word is always followed by its update phase
	a_accept_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_UPDATE))
		else $error("accept not followed by update phase");

	// the clearing pass ends only on its last entry
	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) && !status.clear_last |=> (state_q == ST_CLEAR))
		else $error("clearing pass left early");

endmodule

@@ hw/rtl/srf_datapath.sv @@
// srf_datapath: weight table, relation flags, counters and output register
// depends on srf_pkg; driven by srf_ctrl commands
`timescale 1ns / 1ps

module srf_datapath
	import srf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_cmd_t              cmd,
	output dp_status_t             status,
	input  logic [IDX_W-1:0]       in_idx,
	input  logic                   in_last,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [LIMIT_W-1:0]     cfg_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data
);

	// weight table
	logic [WEIGHT_W-1:0] weight_mem [TABLE_DEPTH];

	logic [TBL_AW-1:0]   clear_addr_q;
	logic [IDX_W-1:0]    idx_s1;
	logic                last_s1;
	logic [WEIGHT_W-1:0] weight_s1;

	logic                pass_mode_q;
	logic [LIMIT_W-1:0]  col_limit_q;
	logic [IDX_W-1:0]    prev_idx_q;
	logic                prev_valid_q;
	logic                single_q;
	logic                range_q;
	logic                zero_q;
	logic [NZ_W-1:0]     nz_q;
	logic [CNT_W-1:0]    total_q;
	logic [CNT_W-1:0]    kept_q;

	logic                out_valid_q;
	logic                keep_q;
	logic                oor_q;
	logic                zero_out_q;
	logic [NZOUT_W-1:0]  nz_out_q;
	logic [CNT_W-1:0]    total_out_q;
	logic [CNT_W-1:0]    kept_out_q;

	logic                in_range;
	logic                new_run;
	logic                wt_inc;
	logic                single_d;
	logic                range_d;
	logic                zero_d;
	logic                keep_d;
	logic                emit;
	logic [TBL_AW-1:0]   upd_addr;

	// update phase decisions
	always_comb begin
		in_range = ({1'b0, idx_s1} < col_limit_q) && (32'(idx_s1) < 32'(TABLE_DEPTH));
		new_run  = !prev_valid_q || (idx_s1 != prev_idx_q);
		wt_inc   = in_range && !pass_mode_q && new_run && (weight_s1 != WEIGHT_MAX);
		single_d = single_q || (in_range && pass_mode_q && (weight_s1 == WEIGHT_W'(1)));
		zero_d   = zero_q || (in_range && pass_mode_q && (weight_s1 == '0));
		range_d  = range_q || !in_range;
		keep_d   = pass_mode_q && !single_d;
		emit     = cmd.update && last_s1;
		upd_addr = TBL_AW'(idx_s1);
	end

	assign status.clear_last = (clear_addr_q == TBL_AW'(TABLE_DEPTH - 1));
	assign status.emit_stall = last_s1 && out_valid_q && !out_ready;

	// table write port: clearing pass or weight increment
	always_ff @(posedge clk) begin
		if (cmd.clear_wr) begin
			weight_mem[clear_addr_q] <= '0;
		end else if (cmd.update && wt_inc) begin
			weight_mem[upd_addr] <= weight_s1 + WEIGHT_W'(1);
		end
	end

	// table read port and input capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			weight_s1 <= weight_mem[TBL_AW'(in_idx)];
			idx_s1    <= in_idx;
			last_s1   <= in_last;
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_addr_q <= '0;
		end else if (cmd.clear_wr && !status.clear_last) begin
			clear_addr_q <= clear_addr_q + TBL_AW'(1);
		end
	end

	// relation state, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_mode_q  <= 1'b0;
			col_limit_q  <= COL_LIMIT_RST;
			prev_idx_q   <= '0;
			prev_valid_q <= 1'b0;
			single_q     <= 1'b0;
			range_q      <= 1'b0;
			zero_q       <= 1'b0;
			nz_q         <= '0;
			total_q      <= '0;
			kept_q       <= '0;
		end else begin
			if (cmd.update) begin
				if (wt_inc && (weight_s1 == '0)) begin
					nz_q <= nz_q + NZ_W'(1);
				end
				if (last_s1) begin
					prev_idx_q   <= '0;
					prev_valid_q <= 1'b0;
					single_q     <= 1'b0;
					range_q      <= 1'b0;
					zero_q       <= 1'b0;
					total_q      <= total_q + CNT_W'(1);
					kept_q       <= kept_q + CNT_W'(keep_d);
				end else begin
					single_q <= single_d;
					range_q  <= range_d;
					zero_q   <= zero_d;
					if (in_range && !pass_mode_q) begin
						prev_idx_q   <= idx_s1;
						prev_valid_q <= 1'b1;
					end
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PASS_MODE: begin
						pass_mode_q  <= cfg_data[0];
						total_q      <= '0;
						kept_q       <= '0;
						prev_idx_q   <= '0;
						prev_valid_q <= 1'b0;
						single_q     <= 1'b0;
						range_q      <= 1'b0;
						zero_q       <= 1'b0;
					end
					REG_COL_LIMIT: begin
						col_limit_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			keep_q      <= keep_d;
			oor_q       <= range_d;
			zero_out_q  <= pass_mode_q && zero_d;
			nz_out_q    <= NZOUT_W'(nz_q + NZ_W'(wt_inc && (weight_s1 == '0)));
			total_out_q <= total_q + CNT_W'(1);
			kept_out_q  <= kept_q + CNT_W'(keep_d);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {kept_out_q, total_out_q, nz_out_q, zero_out_q, oor_q, keep_q};

	// commands never overlap
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_wr, cmd.accept, cmd.update}))
		else $error("overlapping controller commands");

	// a result is never written over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !(out_valid_q && !out_ready))
		else $error("pending result overwritten");

	// a finished relation shows a result next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("finished relation gave no result");

	// nonzero count is bounded by the table size
	a_nz_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(nz_q) <= 32'(TABLE_DEPTH))
		else $error("nonzero ideal count beyond table size");

endmodule

@@ verif/relation_verdict_checker.sv @@
`timescale 1ns / 1ps
// relation_verdict_checker: watches the ideal and result streams of
// singleton_relation_filter, predicts each relation verdict and compares it
// depends on srf_pkg

module relation_verdict_checker
	import srf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [LIMIT_W-1:0]     cfg_data,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [19:0] ideal_index, rest zero
	input  logic                   s_tlast,  // last_in_relation
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] keep_relation, [1] index_out_of_range, [2] zero_weight_seen,
	// [23:3] nonzero_ideals, [55:24] relations_seen, [87:56] relations_kept
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	output int                     failures,
	output int                     pending,
	output int                     checked
);

	// result word layout, top field first
	typedef struct packed {
		logic [CNT_W-1:0]   kept;
		logic [CNT_W-1:0]   seen;
		logic [NZOUT_W-1:0] nonzero;
		logic               zero_seen;
		logic               out_of_range;
		logic               keep;
	} verdict_t;

	// predicted block state
	logic [WEIGHT_W-1:0] weight_tab [logic [IDX_W-1:0]];
	logic [IDX_W-1:0]    prev_idx;
	bit                  prev_ok;
	bit                  single_hit;
	bit                  range_hit;
	bit                  zero_hit;
	logic [CNT_W-1:0]    nonzero_cnt;
	logic [CNT_W-1:0]    rel_total;
	logic [CNT_W-1:0]    kept_total;
	logic                filter_mode;
	logic [LIMIT_W-1:0]  col_limit;

	verdict_t expected_verdicts [$];
	verdict_t want;
	verdict_t got;
	int       err_cnt;
	int       n_checked;

	// per-relation flags back to the start of a relation
	function automatic void new_relation();
		prev_idx   = '0;
		prev_ok    = 1'b0;
		single_hit = 1'b0;
		range_hit  = 1'b0;
		zero_hit   = 1'b0;
	endfunction

	// one ideal into the predicted state; returns 1 when it closes a relation
	function automatic bit apply_ideal(input logic [IDX_W-1:0] idx, input logic last,
			output verdict_t v);
		logic [WEIGHT_W-1:0] w;
		bit                  keep;
		v = '0;
		// indices are below the table depth by width, so only the limit matters
		if ({1'b0, idx} >= col_limit) begin
			range_hit = 1'b1;
		end else if (filter_mode) begin
			w = weight_tab.exists(idx) ? weight_tab[idx] : '0;
			if (w == '0)
				zero_hit = 1'b1;
			if (w == WEIGHT_W'(1))
				single_hit = 1'b1;
		end else begin
			// a new run of this ideal within the relation adds one, up to saturation
			if (!prev_ok || idx != prev_idx) begin
				w = weight_tab.exists(idx) ? weight_tab[idx] : '0;
				if (w != WEIGHT_MAX) begin
					if (w == '0)
						nonzero_cnt++;
					weight_tab[idx] = w + WEIGHT_W'(1);
				end
			end
			prev_idx = idx;
			prev_ok  = 1'b1;
		end
		if (!last)
			return 1'b0;
		keep = filter_mode && !single_hit;
		rel_total++;
		if (keep)
			kept_total++;
		v.keep         = keep;
		v.out_of_range = range_hit;
		v.zero_seen    = filter_mode && zero_hit;
		v.nonzero      = nonzero_cnt[NZOUT_W-1:0];
		v.seen         = rel_total;
		v.kept         = kept_total;
		new_relation();
		return 1'b1;
	endfunction

	task automatic compare_field(input string field, input logic [CNT_W-1:0] want_v,
			input logic [CNT_W-1:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0d, got %0d", field, want_v, got_v);
			err_cnt++;
		end
	endtask

	// results first, then register writes, then the accepted ideal word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_tab.delete();
			expected_verdicts.delete();
			new_relation();
			nonzero_cnt = '0;
			rel_total   = '0;
			kept_total  = '0;
			filter_mode = 1'b0;
			col_limit   = COL_LIMIT_RST;
			err_cnt     = 0;
			n_checked   = 0;
			failures   <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = verdict_t'(m_tdata);
				if (expected_verdicts.size() == 0) begin
					$error("result word with no relation waiting: %h", m_tdata);
					err_cnt++;
				end else begin
					want = expected_verdicts.pop_front();
					compare_field("keep_relation", CNT_W'(want.keep), CNT_W'(got.keep));
					compare_field("index_out_of_range", CNT_W'(want.out_of_range),
						CNT_W'(got.out_of_range));
					compare_field("zero_weight_seen", CNT_W'(want.zero_seen),
						CNT_W'(got.zero_seen));
					compare_field("nonzero_ideals", CNT_W'(want.nonzero), CNT_W'(got.nonzero));
					compare_field("relations_seen", want.seen, got.seen);
					compare_field("relations_kept", want.kept, got.kept);
					n_checked++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PASS_MODE: begin
						filter_mode = cfg_data[0];
						rel_total   = '0;
						kept_total  = '0;
						new_relation();
					end
					REG_COL_LIMIT: begin
						col_limit = cfg_data;
					end
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (apply_ideal(s_tdata[IDX_W-1:0], s_tlast, want))
					expected_verdicts.push_back(want);
			end
			failures <= err_cnt;
			pending  <= expected_verdicts.size();
			checked  <= n_checked;
		end
	end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// testbench: drives ideal words and register writes into singleton_relation_filter
// and gives the verdict; depends on srf_pkg and relation_verdict_checker

module testbench;
	import srf_pkg::*;

	localparam int   NUM_HOT     = 16;
	localparam int   HOT_W       = $clog2(NUM_HOT);
	localparam logic MODE_COUNT  = 1'b0;
	localparam logic MODE_FILTER = 1'b1;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_PASS_MODE;
	logic [LIMIT_W-1:0]     cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;  // [19:0] ideal_index, rest zero
	logic                   s_tlast   = 1'b0;  // last_in_relation
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	// [0] keep_relation, [1] index_out_of_range, [2] zero_weight_seen,
	// [23:3] nonzero_ideals, [55:24] relations_seen, [87:56] relations_kept
	logic [OUT_TDATA_W-1:0] m_tdata;

	int               failures;
	int               pending;
	int               checked;
	bit               calm       = 1'b0;
	int               words_sent = 0;
	int               reg_writes = 0;
	logic [IDX_W-1:0] hot_ideals [NUM_HOT];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	singleton_relation_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	relation_verdict_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.failures  (failures),
		.pending   (pending),
		.checked   (checked)
	);

	// register write once the stream is drained and the pipeline has settled
	task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [LIMIT_W-1:0] value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
	endtask

	// one ideal word, with an occasional gap in front
	task automatic send_ideal(input logic [IDX_W-1:0] idx, input logic last);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'(idx);
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		words_sent++;
	endtask

	// mostly hot ideals so weights build up, some repeats, some anywhere
	task automatic send_relation(input int len, input bit complete);
		logic [IDX_W-1:0] idx;
		int               pick;
		idx = hot_ideals[HOT_W'(0)];
		for (int k = 0; k < len; k++) begin
			pick = $urandom_range(0, 99);
			if (k == 0 || pick >= 15) begin
				if (pick < 80)
					idx = hot_ideals[HOT_W'($urandom_range(0, NUM_HOT - 1))];
				else
					idx = IDX_W'($urandom);
			end
			send_ideal(idx, complete && k == len - 1);
		end
	endtask

	task automatic run_phase(input logic mode, input logic [LIMIT_W-1:0] limit,
			input int n_words, input bit leave_open);
		int start;
		write_reg(REG_COL_LIMIT, limit);
		write_reg(REG_PASS_MODE, LIMIT_W'(mode));
		start = words_sent;
		while (words_sent - start < n_words)
			send_relation($urandom_range(1, 6), 1'b1);
		// break off a relation; the next pass_mode write drops it
		if (leave_open && $urandom_range(0, 1) == 1)
			send_relation($urandom_range(1, 3), 1'b0);
	endtask

	// result side stalls in bursts, none in the closing phase
	initial begin
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// room for the clearing pass over the whole table plus the whole stream, several times over
	initial begin
		#(50_000_000);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		logic [IDX_W-1:0] sat_idx;
		int               guard;
		for (int i = 0; i < NUM_HOT; i++) begin
			if (i < 6)
				hot_ideals[HOT_W'(i)] = IDX_W'(i);
			else if (i == 6)
				hot_ideals[HOT_W'(i)] = 20'hFFFFF;
			else if (i == 7)
				hot_ideals[HOT_W'(i)] = 20'hFFFFE;
			else if (i < 12)
				hot_ideals[HOT_W'(i)] = IDX_W'($urandom_range(6, 63));
			else
				hot_ideals[HOT_W'(i)] = IDX_W'($urandom);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// count mode: index extremes, a run of one ideal, a run that comes back
		write_reg(REG_COL_LIMIT, COL_LIMIT_RST);
		write_reg(REG_PASS_MODE, LIMIT_W'(MODE_COUNT));
		send_ideal(20'h00000, 1'b1);
		send_ideal(20'hFFFFF, 1'b1);
		send_ideal(20'd5, 1'b0);
		send_ideal(20'd5, 1'b0);
		send_ideal(20'd5, 1'b1);
		send_ideal(20'd7, 1'b0);
		send_ideal(20'd8, 1'b0);
		send_ideal(20'd7, 1'b1);
		send_ideal(20'd9, 1'b1);

		// ignored index inside a run, and one carrying the last mark
		write_reg(REG_COL_LIMIT, 21'd8);
		send_ideal(20'd3, 1'b0);
		send_ideal(20'd12, 1'b0);
		send_ideal(20'd3, 1'b1);
		send_ideal(20'd2, 1'b0);
		send_ideal(20'hFFFFF, 1'b1);

		// filter mode: singleton, weight two, unseen ideal, a mix
		write_reg(REG_COL_LIMIT, COL_LIMIT_RST);
		write_reg(REG_PASS_MODE, LIMIT_W'(MODE_FILTER));
		send_ideal(20'd9, 1'b1);
		send_ideal(20'd7, 1'b1);
		send_ideal(20'd100, 1'b1);
		send_ideal(20'd5, 1'b0);
		send_ideal(20'hFFFFE, 1'b0);
		send_ideal(20'd8, 1'b1);

		// smallest limit, then a mode write in the middle of a relation
		write_reg(REG_COL_LIMIT, 21'd1);
		send_ideal(20'd0, 1'b0);
		send_ideal(20'd7, 1'b1);
		send_ideal(20'd0, 1'b0);
		send_ideal(20'd5, 1'b0);
		write_reg(REG_PASS_MODE, LIMIT_W'(MODE_COUNT));
		send_ideal(20'd0, 1'b1);

		// saturate one hot ideal with single-ideal relations
		write_reg(REG_COL_LIMIT, COL_LIMIT_RST);
		sat_idx = hot_ideals[HOT_W'($urandom_range(1, 5))];
		repeat (260) send_ideal(sat_idx, 1'b1);

		// random relations over a spread of settings
		run_phase(MODE_FILTER, COL_LIMIT_RST, 55, 1'b1);
		run_phase(MODE_COUNT, LIMIT_W'($urandom_range(2, 64)), 55, 1'b1);
		run_phase(MODE_FILTER, 21'd1, 55, 1'b1);
		run_phase(MODE_FILTER, LIMIT_W'($urandom_range(1, 1048576)), 55, 1'b1);
		run_phase(MODE_COUNT, COL_LIMIT_RST, 55, 1'b1);
		run_phase(MODE_COUNT, LIMIT_W'($urandom_range(1, 1048576)), 55, 1'b1);
		run_phase(MODE_FILTER, LIMIT_W'($urandom_range(2, 64)), 55, 1'b1);
		calm = 1'b1;
		run_phase(MODE_FILTER, COL_LIMIT_RST, 60, 1'b0);

		// drain and let the pipeline settle
		s_tvalid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (pending != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		$display("sent %0d ideal words and %0d register writes;", words_sent, reg_writes);
		$display("%0d relation results compared, %0d left waiting", checked, pending);
		$display("count and filter passes, limits from one to the full table, saturation, broken relations");
		if (failures == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/srf_pkg.sv
hw/rtl/srf_ctrl.sv
hw/rtl/srf_datapath.sv
hw/rtl/singleton_relation_filter.sv
verif/relation_verdict_checker.sv
verif/testbench.sv
